// ===== design/xyzc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xyzc_pkg
// Shared widths, types and register codes of the chromaticity to RGB converter.
// ----------------------------------------------------------------------------
package xyzc_pkg;

    // Fraction bits of every register, input and output value.
    localparam int FRAC_BITS = 16;

    // Cross products are floored by this many bits when they would grow too wide.
    localparam int DOT_SHIFT = (3 * FRAC_BITS > 59) ? (3 * FRAC_BITS - 59) : 0;

    // Datapath widths.
    localparam int VEC_W   = FRAC_BITS + 2;          // x, y and 1 - x - y, signed
    localparam int CROSS_W = 2 * VEC_W;              // one cross product term, signed
    localparam int ROW_W   = CROSS_W - DOT_SHIFT;    // matrix element, signed
    localparam int DPROD_W = ROW_W + VEC_W;          // element times vector component
    localparam int DOT_W   = DPROD_W + 2;            // row applied to a vector, signed
    localparam int NUM1_W  = FRAC_BITS + DOT_W;      // white_y times dot magnitude
    localparam int QUO1_W  = FRAC_BITS + 31;         // channel magnitude before fixes
    localparam int DIV1_W  = DOT_W + QUO1_W;         // first divider working width
    localparam int CH_W    = FRAC_BITS + 32;         // signed channel
    localparam int QUO2_W  = FRAC_BITS + 1;          // normalized channel
    localparam int DIV2_W  = CH_W + QUO2_W;          // second divider working width
    localparam int OUT_W   = FRAC_BITS + 1;

    // Element types.
    typedef logic signed [VEC_W-1:0]   t_vcomp;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic signed [ROW_W-1:0]   t_row;
    typedef logic signed [DPROD_W-1:0] t_dprod;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic signed [CH_W-1:0]    t_ch;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_RED_X   = 3'd0,
        CFG_RED_Y   = 3'd1,
        CFG_GREEN_X = 3'd2,
        CFG_GREEN_Y = 3'd3,
        CFG_BLUE_X  = 3'd4,
        CFG_BLUE_Y  = 3'd5,
        CFG_WHITE_X = 3'd6,
        CFG_WHITE_Y = 3'd7
    } t_cfg_idx;

    // Configured primaries and white point.
    typedef struct packed {
        logic [FRAC_BITS-1:0] red_x;
        logic [FRAC_BITS-1:0] red_y;
        logic [FRAC_BITS-1:0] green_x;
        logic [FRAC_BITS-1:0] green_y;
        logic [FRAC_BITS-1:0] blue_x;
        logic [FRAC_BITS-1:0] blue_y;
        logic [FRAC_BITS-1:0] white_x;
        logic [FRAC_BITS-1:0] white_y;
    } t_cfg;

    // Input transaction payload.
    typedef struct packed {
        logic [FRAC_BITS-1:0] chroma_x;
        logic [FRAC_BITS-1:0] chroma_y;
        logic [FRAC_BITS-1:0] chroma_z;
    } t_item;

    // Result transaction payload.
    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
        logic             invalid;
    } t_result;

    // Rescales a reset value given for 16 fraction bits.
    function automatic logic [FRAC_BITS-1:0] rst16(input logic [63:0] v);
        return FRAC_BITS'((v << FRAC_BITS) >> 16);
    endfunction

    // Third component of a chromaticity vector: 1 - x - y.
    function automatic t_vcomp vec_z(input logic [FRAC_BITS-1:0] x,
                                     input logic [FRAC_BITS-1:0] y);
        logic [VEC_W-1:0] one_v;
        one_v = VEC_W'(1) << FRAC_BITS;
        return $signed(one_v - {2'b00, x} - {2'b00, y});
    endfunction

    // A chromaticity coordinate as a signed vector component.
    function automatic t_vcomp vec_c(input logic [FRAC_BITS-1:0] x);
        return $signed({2'b00, x});
    endfunction

endpackage
`default_nettype wire

// ===== design/xyzc_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xyzc_matrix
// Builds the conversion matrix from the primaries and applies it to the
// white point and to the input, giving numerators and divisors per channel.
// ----------------------------------------------------------------------------
module xyzc_matrix (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire xyzc_pkg::t_cfg                            i_cfg,
    input  wire logic                                      i_valid,
    input  wire xyzc_pkg::t_item                           i_item,
    output logic                                           o_valid,
    output logic [2:0][xyzc_pkg::DIV1_W-1:0]               o_num,
    output logic [2:0][xyzc_pkg::DOT_W-1:0]                o_den,
    output logic [2:0]                                     o_neg,
    output logic                                           o_bad
);

    xyzc_pkg::t_vcomp c_vec [4][3];
    xyzc_pkg::t_vcomp c_white [3];

    logic [4:0] r_valid;
    logic [xyzc_pkg::FRAC_BITS-1:0] r1_v [3];
    logic [xyzc_pkg::FRAC_BITS-1:0] r2_v [3];
    xyzc_pkg::t_cross r1_pa [3][3];
    xyzc_pkg::t_cross r1_pb [3][3];
    xyzc_pkg::t_row   r2_row [3][3];
    xyzc_pkg::t_dprod r3_pw [3][3];
    xyzc_pkg::t_dprod r3_pv [3][3];
    xyzc_pkg::t_dot   r4_nw [3];
    xyzc_pkg::t_dot   r4_nv [3];

    // Primary vectors: red, green, blue, then white.
    always_comb begin
        c_vec[0][0] = xyzc_pkg::vec_c(i_cfg.red_x);
        c_vec[0][1] = xyzc_pkg::vec_c(i_cfg.red_y);
        c_vec[0][2] = xyzc_pkg::vec_z(i_cfg.red_x, i_cfg.red_y);
        c_vec[1][0] = xyzc_pkg::vec_c(i_cfg.green_x);
        c_vec[1][1] = xyzc_pkg::vec_c(i_cfg.green_y);
        c_vec[1][2] = xyzc_pkg::vec_z(i_cfg.green_x, i_cfg.green_y);
        c_vec[2][0] = xyzc_pkg::vec_c(i_cfg.blue_x);
        c_vec[2][1] = xyzc_pkg::vec_c(i_cfg.blue_y);
        c_vec[2][2] = xyzc_pkg::vec_z(i_cfg.blue_x, i_cfg.blue_y);
        c_vec[3][0] = xyzc_pkg::vec_c(i_cfg.white_x);
        c_vec[3][1] = xyzc_pkg::vec_c(i_cfg.white_y);
        c_vec[3][2] = xyzc_pkg::vec_z(i_cfg.white_x, i_cfg.white_y);
        for (int j = 0; j < 3; j++) begin
            c_white[j] = c_vec[3][j];
        end
    end

    // Valid bits travel with the data through all five stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    // Stage 1 captures the input; stage 2 carries it on.
    always_ff @(posedge i_clk) begin
        r1_v[0] <= i_item.chroma_x;
        r1_v[1] <= i_item.chroma_y;
        r1_v[2] <= i_item.chroma_z;
        r2_v    <= r1_v;
    end

    // Rows are green x blue, blue x red and red x green.
    for (genvar k = 0; k < 3; k++) begin : g_row
        localparam int KA = (k + 1) % 3;
        localparam int KB = (k + 2) % 3;
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int J1 = (j + 1) % 3;
            localparam int J2 = (j + 2) % 3;
            always_ff @(posedge i_clk) begin
                // Stage 1: the two products of each cross product term.
                r1_pa[k][j] <= c_vec[KA][J1] * c_vec[KB][J2];
                r1_pb[k][j] <= c_vec[KB][J1] * c_vec[KA][J2];
                // Stage 2: difference, floored by the row shift.
                r2_row[k][j] <= xyzc_pkg::ROW_W'((r1_pa[k][j] - r1_pb[k][j])
                                                 >>> xyzc_pkg::DOT_SHIFT);
                // Stage 3: element times white and input components.
                r3_pw[k][j] <= r2_row[k][j] * c_white[j];
                r3_pv[k][j] <= r2_row[k][j] * xyzc_pkg::vec_c(r2_v[j]);
            end
        end
        // Stage 4: dot products.
        always_ff @(posedge i_clk) begin
            r4_nw[k] <= xyzc_pkg::DOT_W'(r3_pw[k][0]) + xyzc_pkg::DOT_W'(r3_pw[k][1])
                      + xyzc_pkg::DOT_W'(r3_pw[k][2]);
            r4_nv[k] <= xyzc_pkg::DOT_W'(r3_pv[k][0]) + xyzc_pkg::DOT_W'(r3_pv[k][1])
                      + xyzc_pkg::DOT_W'(r3_pv[k][2]);
        end
    end

    // Stage 5: scaled numerator, divisor magnitude, sign and degenerate flag.
    logic [xyzc_pkg::DOT_W-1:0]  c_mag_v [3];
    logic [xyzc_pkg::NUM1_W-1:0] c_num [3];
    logic                        c_bad;

    always_comb begin
        c_bad = (i_cfg.white_y == '0);
        for (int k = 0; k < 3; k++) begin
            c_mag_v[k] = r4_nv[k][xyzc_pkg::DOT_W-1] ? -r4_nv[k] : r4_nv[k];
            c_num[k]   = xyzc_pkg::NUM1_W'(i_cfg.white_y)
                       * xyzc_pkg::NUM1_W'(c_mag_v[k]);
            if (r4_nw[k] == '0) begin
                c_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            o_num[k] <= xyzc_pkg::DIV1_W'(c_num[k]);
            o_den[k] <= r4_nw[k][xyzc_pkg::DOT_W-1] ? -r4_nw[k] : r4_nw[k];
            o_neg[k] <= r4_nv[k][xyzc_pkg::DOT_W-1] ^ r4_nw[k][xyzc_pkg::DOT_W-1];
        end
        o_bad <= c_bad;
    end

    assign o_valid = r_valid[4];

endmodule
`default_nettype wire

// ===== design/xyzc_div_lanes.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xyzc_div_lanes
// Three-lane pipelined restoring divider, one quotient bit per stage, with a
// saturating quotient when it would not fit.
// ----------------------------------------------------------------------------
module xyzc_div_lanes #(
    parameter int DEN_W  = xyzc_pkg::DOT_W,
    parameter int QUO_W  = xyzc_pkg::QUO1_W,
    parameter int SIDE_W = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [2:0][DEN_W+QUO_W-1:0]     i_num,
    input  wire logic [2:0][DEN_W-1:0]           i_den,
    input  wire logic [SIDE_W-1:0]               i_side,
    output logic                                 o_valid,
    output logic [2:0][QUO_W-1:0]                o_quo,
    output logic [SIDE_W-1:0]                    o_side
);

    localparam int W = DEN_W + QUO_W;

    logic [QUO_W:0]      r_valid;
    logic [W-1:0]        r_rem  [0:QUO_W-1][3];
    logic [DEN_W-1:0]    r_den  [0:QUO_W-1][3];
    logic [QUO_W-1:0]    r_q    [0:QUO_W][3];
    logic [2:0]          r_sat  [0:QUO_W];
    logic [SIDE_W-1:0]   r_side [0:QUO_W];

    // Stage 0: capture and check whether the quotient overflows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_rem[0][l] <= i_num[l];
            r_den[0][l] <= i_den[l];
            r_q[0][l]   <= '0;
            r_sat[0][l] <= (i_num[l][W-1:QUO_W] >= i_den[l]);
        end
        r_side[0] <= i_side;
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
        localparam int B = QUO_W - s;
        logic [W-1:0] c_sub [3];
        logic [2:0]   c_ge;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                c_sub[l] = W'(r_den[s-1][l]) << B;
                c_ge[l]  = (r_rem[s-1][l] >= c_sub[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= r_valid[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 3; l++) begin
                r_q[s][l] <= r_q[s-1][l] | (QUO_W'(c_ge[l]) << B);
            end
            r_sat[s]  <= r_sat[s-1];
            r_side[s] <= r_side[s-1];
        end

        // The remainder and divisor are needed only by later stages.
        if (s < QUO_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[s][l] <= c_ge[l] ? (r_rem[s-1][l] - c_sub[l]) : r_rem[s-1][l];
                    r_den[s][l] <= r_den[s-1][l];
                end
            end
        end
    end

    // Saturated lanes read as all ones.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_sat[QUO_W][l] ? '1 : r_q[QUO_W][l];
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule
`default_nettype wire

// ===== design/xyzc_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xyzc_norm
// Signs the channels, adds white to lift negatives and prepares the division
// that brings the largest channel down to one.
// ----------------------------------------------------------------------------
module xyzc_norm (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    input  wire logic [2:0][xyzc_pkg::QUO1_W-1:0]       i_quo,
    input  wire logic [2:0]                             i_neg,
    input  wire logic                                   i_bad,
    output logic                                        o_valid,
    output logic [2:0][xyzc_pkg::DIV2_W-1:0]            o_num,
    output logic [2:0][xyzc_pkg::CH_W-1:0]              o_den,
    output logic                                        o_bad
);

    logic [3:0] r_valid;
    logic [3:0] r_bad;
    xyzc_pkg::t_ch            r1_ch [3];
    logic [xyzc_pkg::CH_W-1:0] r2_sh [3];
    logic [xyzc_pkg::CH_W-1:0] r3_sh [3];
    logic [xyzc_pkg::CH_W-1:0] r3_top;
    logic                      r3_big;
    xyzc_pkg::t_ch             c_low;
    logic [xyzc_pkg::CH_W-1:0] c_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // Most negative channel, zero if none is negative.
    always_comb begin
        c_low = '0;
        for (int k = 0; k < 3; k++) begin
            if (r1_ch[k] < c_low) begin
                c_low = r1_ch[k];
            end
        end
    end

    // Largest channel after the white lift.
    always_comb begin
        c_top = '0;
        for (int k = 0; k < 3; k++) begin
            if (r2_sh[k] > c_top) begin
                c_top = r2_sh[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bad <= {r_bad[2:0], i_bad};
        for (int k = 0; k < 3; k++) begin
            // Stage 1: apply the sign.
            r1_ch[k] <= i_neg[k] ? -xyzc_pkg::t_ch'(i_quo[k]) : xyzc_pkg::t_ch'(i_quo[k]);
            // Stage 2: lift by the most negative channel.
            r2_sh[k] <= xyzc_pkg::CH_W'(r1_ch[k] - c_low);
            // Stage 3: hold the lifted channel next to the maximum.
            r3_sh[k] <= r2_sh[k];
            // Stage 4: divide by the maximum only when it exceeds one.
            o_num[k] <= r3_big ? (xyzc_pkg::DIV2_W'(r3_sh[k]) << xyzc_pkg::FRAC_BITS)
                               : xyzc_pkg::DIV2_W'(r3_sh[k]);
            o_den[k] <= r3_big ? r3_top : xyzc_pkg::CH_W'(1);
        end
        r3_top <= c_top;
        r3_big <= (c_top > (xyzc_pkg::CH_W'(1) << xyzc_pkg::FRAC_BITS));
    end

    assign o_valid = r_valid[3];
    assign o_bad   = r_bad[3];

endmodule
`default_nettype wire

// ===== design/xyz_chromaticity_to_rgb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xyz_chromaticity_to_rgb
// Converts a CIE chromaticity triple to linear RGB for a configured color
// system, with white lift and normalization to one.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle and never raises busy.
// Each result comes out on o_result with a one-cycle o_done strobe. The
// pipeline holds two bit-per-stage dividers in series: 47 stages for
// the channel scaling and 17 for the normalization, plus twelve stages for
// the matrix, the two divider input registers, the white lift and the output
// register. The receiver cannot stall, so results must be taken as they
// appear. Registers are to be written by the user through i_cfg_we, i_cfg_idx
// and i_cfg_wdata only while no transaction is in flight; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module xyz_chromaticity_to_rgb (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire xyzc_pkg::t_item                     i_item,
    output logic                                     o_done,
    output xyzc_pkg::t_result                        o_result,
    input  wire logic                                i_cfg_we,
    input  wire logic [2:0]                          i_cfg_idx,
    input  wire logic [xyzc_pkg::FRAC_BITS-1:0]      i_cfg_wdata
);

    localparam int LATENCY = xyzc_pkg::QUO1_W + xyzc_pkg::QUO2_W + 12;

    xyzc_pkg::t_cfg    r_cfg;
    logic              r_done;
    xyzc_pkg::t_result r_result;

    logic                                   mx_valid;
    logic [2:0][xyzc_pkg::DIV1_W-1:0]       mx_num;
    logic [2:0][xyzc_pkg::DOT_W-1:0]        mx_den;
    logic [2:0]                             mx_neg;
    logic                                   mx_bad;
    logic                                   d1_valid;
    logic [2:0][xyzc_pkg::QUO1_W-1:0]       d1_quo;
    logic [3:0]                             d1_side;
    logic                                   nm_valid;
    logic [2:0][xyzc_pkg::DIV2_W-1:0]       nm_num;
    logic [2:0][xyzc_pkg::CH_W-1:0]         nm_den;
    logic                                   nm_bad;
    logic                                   d2_valid;
    logic [2:0][xyzc_pkg::QUO2_W-1:0]       d2_quo;
    logic                                   d2_bad;

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_x   <= xyzc_pkg::rst16(64'd41943);
            r_cfg.red_y   <= xyzc_pkg::rst16(64'd21627);
            r_cfg.green_x <= xyzc_pkg::rst16(64'd19661);
            r_cfg.green_y <= xyzc_pkg::rst16(64'd39322);
            r_cfg.blue_x  <= xyzc_pkg::rst16(64'd9830);
            r_cfg.blue_y  <= xyzc_pkg::rst16(64'd3932);
            r_cfg.white_x <= xyzc_pkg::rst16(64'd20493);
            r_cfg.white_y <= xyzc_pkg::rst16(64'd21561);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                xyzc_pkg::CFG_RED_X:   r_cfg.red_x   <= i_cfg_wdata;
                xyzc_pkg::CFG_RED_Y:   r_cfg.red_y   <= i_cfg_wdata;
                xyzc_pkg::CFG_GREEN_X: r_cfg.green_x <= i_cfg_wdata;
                xyzc_pkg::CFG_GREEN_Y: r_cfg.green_y <= i_cfg_wdata;
                xyzc_pkg::CFG_BLUE_X:  r_cfg.blue_x  <= i_cfg_wdata;
                xyzc_pkg::CFG_BLUE_Y:  r_cfg.blue_y  <= i_cfg_wdata;
                xyzc_pkg::CFG_WHITE_X: r_cfg.white_x <= i_cfg_wdata;
                xyzc_pkg::CFG_WHITE_Y: r_cfg.white_y <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Matrix and dot products.
    xyzc_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (start & ~busy),
        .i_item  (i_item),
        .o_valid (mx_valid),
        .o_num   (mx_num),
        .o_den   (mx_den),
        .o_neg   (mx_neg),
        .o_bad   (mx_bad)
    );

    // Channel scaling so that white has unit luminance.
    xyzc_div_lanes #(
        .DEN_W  (xyzc_pkg::DOT_W),
        .QUO_W  (xyzc_pkg::QUO1_W),
        .SIDE_W (4)
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mx_valid),
        .i_num   (mx_num),
        .i_den   (mx_den),
        .i_side  ({mx_neg, mx_bad}),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // White lift and maximum.
    xyzc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_valid),
        .i_quo   (d1_quo),
        .i_neg   (d1_side[3:1]),
        .i_bad   (d1_side[0]),
        .o_valid (nm_valid),
        .o_num   (nm_num),
        .o_den   (nm_den),
        .o_bad   (nm_bad)
    );

    // Normalization by the largest channel.
    xyzc_div_lanes #(
        .DEN_W  (xyzc_pkg::CH_W),
        .QUO_W  (xyzc_pkg::QUO2_W),
        .SIDE_W (1)
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nm_valid),
        .i_num   (nm_num),
        .i_den   (nm_den),
        .i_side  (nm_bad),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_bad)
    );

    // Output register; a degenerate configuration gives zeros and the flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.red_out   <= d2_bad ? '0 : d2_quo[0];
        r_result.green_out <= d2_bad ? '0 : d2_quo[1];
        r_result.blue_out  <= d2_bad ? '0 : d2_quo[2];
        r_result.invalid   <= d2_bad;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTH
    // Every accepted transaction gives its result after the fixed latency.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result missing after pipeline latency");

    // A degenerate configuration reports zeros.
    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.invalid) |->
        (o_result.red_out == '0 && o_result.green_out == '0 && o_result.blue_out == '0))
        else $error("invalid result carries nonzero color");

    // Normalized channels never exceed one.
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |->
        (o_result.red_out <= (xyzc_pkg::OUT_W'(1) << xyzc_pkg::FRAC_BITS) &&
         o_result.green_out <= (xyzc_pkg::OUT_W'(1) << xyzc_pkg::FRAC_BITS) &&
         o_result.blue_out <= (xyzc_pkg::OUT_W'(1) << xyzc_pkg::FRAC_BITS)))
        else $error("channel above one");
`endif

endmodule
`default_nettype wire

// ===== sim/xyzc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyzc_checker
// Watches the item, result and register ports of the chromaticity to RGB
// converter, predicts each result from its own copy of the registers and
// compares the results field by field in order.
// ----------------------------------------------------------------------------
module xyzc_checker
    import xyzc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire t_item                i_item,
    input  wire logic                 i_done,
    input  wire t_result              i_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [FRAC_BITS-1:0] i_cfg_wdata,
    output int                        o_errors,
    output int                        o_pending
);

    localparam longint UNIT  = longint'(1) << FRAC_BITS;
    localparam longint LIMIT = (longint'(1) << (FRAC_BITS + 31)) - 1;

    t_cfg    colors;
    t_result rgb_queue[$];

    // Saturating floor(a * b / c) with a full 128-bit product.
    function automatic longint scale_sat(longint a, longint b, longint c, longint lim);
        logic [127:0] prod;
        logic [127:0] quo;
        prod = 128'(a) * 128'(b);
        if ((prod >> 64) >= 128'(c)) return lim;
        quo = prod / 128'(c);
        return (quo > 128'(lim)) ? lim : longint'(quo);
    endfunction

    // Expected RGB for one chromaticity triple under the given registers.
    function automatic t_result convert(t_cfg c, t_item it);
        longint  prim[3][3];
        longint  wv[3];
        longint  iv[3];
        longint  mat[3][3];
        longint  nw[3];
        longint  ch[3];
        longint  nv;
        longint  mag;
        longint  lowest;
        longint  top;
        int      a;
        int      b;
        bit      bad;
        t_result r;
        prim[0] = '{longint'(c.red_x), longint'(c.red_y), UNIT - c.red_x - c.red_y};
        prim[1] = '{longint'(c.green_x), longint'(c.green_y),
                    UNIT - c.green_x - c.green_y};
        prim[2] = '{longint'(c.blue_x), longint'(c.blue_y), UNIT - c.blue_x - c.blue_y};
        wv      = '{longint'(c.white_x), longint'(c.white_y),
                    UNIT - c.white_x - c.white_y};
        iv      = '{longint'(it.chroma_x), longint'(it.chroma_y), longint'(it.chroma_z)};
        bad     = (c.white_y == 0);
        // Row k is the cross product of the two other primaries.
        for (int k = 0; k < 3; k++) begin
            a = (k + 1) % 3;
            b = (k + 2) % 3;
            for (int i = 0; i < 3; i++)
                mat[k][i] = (prim[a][(i+1)%3] * prim[b][(i+2)%3]
                           - prim[b][(i+1)%3] * prim[a][(i+2)%3]) >>> DOT_SHIFT;
            nw[k] = mat[k][0] * wv[0] + mat[k][1] * wv[1] + mat[k][2] * wv[2];
            if (nw[k] == 0) bad = 1'b1;
        end
        r = '0;
        if (bad) begin
            r.invalid = 1'b1;
            return r;
        end
        // Scale each channel so that white has unit luminance.
        lowest = 0;
        for (int k = 0; k < 3; k++) begin
            nv  = mat[k][0] * iv[0] + mat[k][1] * iv[1] + mat[k][2] * iv[2];
            mag = scale_sat(longint'(c.white_y), (nv < 0) ? -nv : nv,
                            (nw[k] < 0) ? -nw[k] : nw[k], LIMIT);
            ch[k] = ((nv < 0) != (nw[k] < 0)) ? -mag : mag;
            if (ch[k] < lowest) lowest = ch[k];
        end
        // Lift by white, then normalize so that a largest channel above one becomes one.
        top = 0;
        for (int k = 0; k < 3; k++) begin
            ch[k] -= lowest;
            if (ch[k] > top) top = ch[k];
        end
        if (top > UNIT)
            for (int k = 0; k < 3; k++) ch[k] = scale_sat(ch[k], UNIT, top, UNIT);
        r.red_out   = OUT_W'(ch[0]);
        r.green_out = OUT_W'(ch[1]);
        r.blue_out  = OUT_W'(ch[2]);
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = rgb_queue.size();

    // Results are checked before the same edge's transaction is predicted.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            colors <= '{41943, 21627, 19661, 39322, 9830, 3932, 20493, 21561};
            rgb_queue.delete();
        end else begin
            if (i_done) begin
                if (rgb_queue.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = rgb_queue.pop_front();
                    if (i_result.red_out != want.red_out)
                        report("red_out", i_result.red_out, want.red_out);
                    if (i_result.green_out != want.green_out)
                        report("green_out", i_result.green_out, want.green_out);
                    if (i_result.blue_out != want.blue_out)
                        report("blue_out", i_result.blue_out, want.blue_out);
                    if (i_result.invalid != want.invalid)
                        report("invalid", i_result.invalid, want.invalid);
                end
            end
            if (i_start && !i_busy)
                rgb_queue.push_back(convert(colors, i_item));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RED_X:   colors.red_x   <= i_cfg_wdata;
                    CFG_RED_Y:   colors.red_y   <= i_cfg_wdata;
                    CFG_GREEN_X: colors.green_x <= i_cfg_wdata;
                    CFG_GREEN_Y: colors.green_y <= i_cfg_wdata;
                    CFG_BLUE_X:  colors.blue_x  <= i_cfg_wdata;
                    CFG_BLUE_Y:  colors.blue_y  <= i_cfg_wdata;
                    CFG_WHITE_X: colors.white_x <= i_cfg_wdata;
                    CFG_WHITE_Y: colors.white_y <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the chromaticity to RGB converter through several register settings,
// directed and random chromaticity transactions and sender idle patterns; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import xyzc_pkg::*;

    localparam int LATENCY   = 2 * FRAC_BITS + 44;
    localparam int MAX_CYCLE = 600000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_item                i_item = '0;
    logic                 o_done;
    t_result              o_result;
    logic                 i_cfg_we = 1'b0;
    logic [2:0]           i_cfg_idx = '0;
    logic [FRAC_BITS-1:0] i_cfg_wdata = '0;
    int                   errors;
    int                   pending;
    int                   cycle = 0;
    int                   idle_pct = 0;

    always #1 i_clk = ~i_clk;

    xyz_chromaticity_to_rgb u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    xyzc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_item(i_item), .i_done(o_done), .i_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE) begin
            $display("FAIL");
            $finish;
        end
    end

    // One transaction; start stays high afterward until the next negedge decides.
    task automatic send(t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_xyz(int x, int y, int z);
        send('{chroma_x: x[15:0], chroma_y: y[15:0], chroma_z: z[15:0]});
    endtask

    // Waits until every result has come back, then lets the pipeline drain.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val[FRAC_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic load_colors(int rx, int ry, int gx, int gy, int bx, int by,
                               int wx, int wy);
        write_reg(CFG_RED_X, rx);   write_reg(CFG_RED_Y, ry);
        write_reg(CFG_GREEN_X, gx); write_reg(CFG_GREEN_Y, gy);
        write_reg(CFG_BLUE_X, bx);  write_reg(CFG_BLUE_Y, by);
        write_reg(CFG_WHITE_X, wx); write_reg(CFG_WHITE_Y, wy);
    endtask

    // Mostly well-formed triples summing near one, plus small and raw noise.
    task automatic random_items(int n);
        int x;
        int y;
        for (int i = 0; i < n; i++) begin
            x = $urandom_range(65535);
            y = $urandom_range(65535 - x);
            case ($urandom_range(9))
                0, 1:    send_xyz($urandom, $urandom, $urandom);
                2:       send_xyz($urandom_range(255), $urandom_range(255),
                                  $urandom_range(255));
                default: send_xyz(x, y, (65536 - x - y > 65535) ? 65535 : 65536 - x - y);
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default registers, field extremes, primaries and white.
        send_xyz(0, 0, 0);
        send_xyz(65535, 65535, 65535);
        send_xyz(65535, 0, 0);
        send_xyz(0, 65535, 0);
        send_xyz(0, 0, 65535);
        send_xyz(1, 1, 1);
        send_xyz(20493, 21561, 65536 - 20493 - 21561);
        send_xyz(41943, 21627, 65536 - 41943 - 21627);
        send_xyz(19661, 39322, 65536 - 19661 - 39322);
        send_xyz(9830, 3932, 65536 - 9830 - 3932);
        send_xyz(32768, 32768, 0);
        send_xyz(43690, 21845, 21845);
        drain();

        // Degenerate settings: all primaries alike, then zero white_y.
        load_colors(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
        send_xyz(100, 200, 300);
        send_xyz(65535, 65535, 65535);
        drain();
        load_colors(41943, 21627, 19661, 39322, 9830, 3932, 20493, 0);
        send_xyz(20000, 20000, 25536);
        drain();
        // Nearly collinear primaries push channels toward saturation.
        load_colors(30000, 30000, 30001, 30000, 30000, 30001, 10000, 50000);
        send_xyz(65535, 0, 0);
        send_xyz(0, 65535, 65535);
        send_xyz(12345, 54321, 0);
        drain();

        // Random phases over several settings and idle patterns.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_colors(41943, 21627, 19661, 39322, 9830, 3932, 20493, 21561);
                1: load_colors(0, 0, 65535, 0, 0, 65535, 21845, 21845);
                2: load_colors(44564, 21627, 17695, 46396, 9830, 3932, 20493, 21561);
                5: load_colors(65535, 65535, 0, 0, 1, 65535, 65535, 1);
                default: load_colors($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom,
                                     $urandom_range(65535, 1));
            endcase
            idle_pct = (ph % 3 == 1) ? 56 : ((ph % 3 == 2) ? 14 : 0);
            random_items(155);
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== xyz_chromaticity_to_rgb.f =====
design/xyzc_pkg.sv
design/xyzc_matrix.sv
design/xyzc_div_lanes.sv
design/xyzc_norm.sv
design/xyz_chromaticity_to_rgb.sv
sim/xyzc_checker.sv
sim/tb.sv
